/* design/lifo_stack_with_swap_and_dump_unit_defines.svh */
// Assertion macros for the LIFO stack unit.
// Used by files that check their own control logic; no dependencies.
`ifndef LIFO_STACK_WITH_SWAP_AND_DUMP_UNIT_DEFINES_SVH
`define LIFO_STACK_WITH_SWAP_AND_DUMP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSSD_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lssd assertion failed");
`define LSSD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lssd assertion failed");
`else
`define LSSD_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define LSSD_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* design/lssd_pkg.sv */
// Package for the LIFO stack unit: sizes, operation and status codes,
// item structs and the control bundle. No dependencies.
`default_nettype none

package lssd_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 7;
    localparam int WORD_W      = 64;

    localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] PTR_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0] PTR_TWO    = CNT_W'(2);
    localparam logic [CNT_W-1:0] PTR_M1     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] PTR_M2     = {{(CNT_W-1){1'b1}}, 1'b0};

    typedef enum logic [2:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_POP   = 3'd1,
        FUNC_PEEK  = 3'd2,
        FUNC_SWAP  = 3'd3,
        FUNC_CLEAR = 3'd4,
        FUNC_DUMP  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_EMPTY  = 3'd2,
        STAT_FEW    = 3'd3,
        STAT_NODUMP = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        WSEL_IN    = 2'd0,
        WSEL_RDATA = 2'd1,
        WSEL_TMP   = 2'd2
    } wsel_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [WORD_W-1:0] push_value;
        logic [CNT_W-1:0]  dump_count;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [2:0]        status;
        logic [CNT_W-1:0]  fill_level;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              mem_we;
        logic [ADDR_W-1:0] mem_waddr;
        wsel_t             wsel;
        logic              mem_re;
        logic [ADDR_W-1:0] mem_raddr;
        logic              tmp_load;
        logic              out_load;
        logic              out_word_rd;
        status_t           out_status;
        logic              out_last;
        logic [CNT_W-1:0]  out_fill;
    } ctl_t;

endpackage

`default_nettype wire

/* design/lifo_stack_with_swap_and_dump_unit.sv */
// Top level of the LIFO stack unit: stack memory, swap holding register and
// result register. Depends on lssd_pkg and lssd_ctrl.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------------
//   input    | s_valid / s_ready | s_item: func, push_value, dump_count
//   result   | m_valid / m_ready | m_item: word_out, status, fill_level, last
//
// Push, clear, refused ops and unused codes: no memory read; pop and peek: one
// memory read; swap: two reads, two writes on the single read port and single
// write port of the stack memory. Dump of n entries: one memory read per
// emitted entry. Reset clears the stack pointer and sequencer; the memory is
// not cleared. A stalled result register stops the sequencer once a result
// is due; input is taken only when idle.
`default_nettype none

module lifo_stack_with_swap_and_dump_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lssd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lssd_pkg::out_item_t m_item
);

    logic [lssd_pkg::WORD_W-1:0] mem [lssd_pkg::STACK_DEPTH];
    logic [lssd_pkg::WORD_W-1:0] rdata_reg;
    logic [lssd_pkg::WORD_W-1:0] tmp_reg;
    logic [lssd_pkg::WORD_W-1:0] wdata;

    logic                m_valid_reg, m_valid_next;
    lssd_pkg::out_item_t m_item_reg, m_item_next;
    logic                out_free;
    lssd_pkg::ctl_t      ctl;

    assign out_free = !m_valid_reg || m_ready;

    lssd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_item   (s_item),
        .s_ready  (s_ready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    always_comb begin
        unique case (ctl.wsel)
            lssd_pkg::WSEL_IN:    wdata = s_item.push_value;
            lssd_pkg::WSEL_RDATA: wdata = rdata_reg;
            lssd_pkg::WSEL_TMP:   wdata = tmp_reg;
            default:              wdata = s_item.push_value;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.mem_we) begin
            mem[ctl.mem_waddr] <= wdata;
        end
        if (ctl.mem_re) begin
            rdata_reg <= mem[ctl.mem_raddr];
        end
        if (ctl.tmp_load) begin
            tmp_reg <= rdata_reg;
        end
    end

    always_comb begin
        m_item_next = m_item_reg;
        if (ctl.out_load) begin
            m_item_next.word_out   = ctl.out_word_rd ? rdata_reg : '0;
            m_item_next.status     = ctl.out_status;
            m_item_next.fill_level = ctl.out_fill;
            m_item_next.last       = ctl.out_last;
        end
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* design/lssd_ctrl.sv */
// Sequencer of the LIFO stack unit: stack pointer, dump walk and the shared
// pointer adder. Depends on lssd_pkg and the assertion macro header.
`default_nettype none
`include "lifo_stack_with_swap_and_dump_unit_defines.svh"

module lssd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  lssd_pkg::in_item_t s_item,
    output logic               s_ready,
    input  logic               out_free,
    output lssd_pkg::ctl_t     ctl
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FETCH  = 7'b0000010,
        ST_SWAP_A = 7'b0000100,
        ST_SWAP_B = 7'b0001000,
        ST_SWAP_C = 7'b0010000,
        ST_RESP   = 7'b0100000,
        ST_DUMP   = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lssd_pkg::CNT_W-1:0]      sp_reg, sp_next;
    logic [lssd_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [lssd_pkg::CNT_W-1:0]      n_reg, n_next;
    lssd_pkg::status_t               status_reg, status_next;

    logic [lssd_pkg::CNT_W-1:0]      alu_a, alu_b, alu_sum;
    logic [lssd_pkg::CNT_W-1:0]      dump_n;
    logic                            dump_last;

    assign alu_sum   = alu_a + alu_b;
    assign dump_n    = (s_item.dump_count < sp_reg) ? s_item.dump_count : sp_reg;
    assign dump_last = (alu_sum == n_reg);
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        status_next = status_reg;
        alu_a       = sp_reg;
        alu_b       = lssd_pkg::PTR_M1;
        ctl             = '0;
        ctl.wsel        = lssd_pkg::WSEL_IN;
        ctl.out_status  = status_reg;
        ctl.out_fill    = sp_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_item.func == lssd_pkg::FUNC_PUSH) begin
                    alu_b = lssd_pkg::PTR_ONE;
                end
                if (s_valid) begin
                    unique case (s_item.func)
                        lssd_pkg::FUNC_PUSH: begin
                            if (sp_reg == lssd_pkg::FULL_LEVEL) begin
                                status_next = lssd_pkg::STAT_FULL;
                            end else begin
                                ctl.mem_we    = 1'b1;
                                ctl.mem_waddr = sp_reg[lssd_pkg::ADDR_W-1:0];
                                sp_next       = alu_sum;
                                status_next   = lssd_pkg::STAT_OK;
                            end
                            state_next = ST_RESP;
                        end
                        lssd_pkg::FUNC_POP, lssd_pkg::FUNC_PEEK: begin
                            if (sp_reg == '0) begin
                                status_next = lssd_pkg::STAT_EMPTY;
                                state_next  = ST_RESP;
                            end else begin
                                ctl.mem_re    = 1'b1;
                                ctl.mem_raddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                                if (s_item.func == lssd_pkg::FUNC_POP) begin
                                    sp_next = alu_sum;
                                end
                                state_next = ST_FETCH;
                            end
                        end
                        lssd_pkg::FUNC_SWAP: begin
                            if (sp_reg < lssd_pkg::PTR_TWO) begin
                                status_next = lssd_pkg::STAT_FEW;
                                state_next  = ST_RESP;
                            end else begin
                                ctl.mem_re    = 1'b1;
                                ctl.mem_raddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                                state_next    = ST_SWAP_A;
                            end
                        end
                        lssd_pkg::FUNC_CLEAR: begin
                            sp_next     = '0;
                            status_next = lssd_pkg::STAT_OK;
                            state_next  = ST_RESP;
                        end
                        lssd_pkg::FUNC_DUMP: begin
                            if (dump_n == '0) begin
                                status_next = lssd_pkg::STAT_NODUMP;
                                state_next  = ST_RESP;
                            end else begin
                                ctl.mem_re    = 1'b1;
                                ctl.mem_raddr = '0;
                                idx_next      = '0;
                                n_next        = dump_n;
                                state_next    = ST_DUMP;
                            end
                        end
                        default: begin
                            status_next = lssd_pkg::STAT_OK;
                            state_next  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                ctl.out_word_rd = 1'b1;
                ctl.out_status  = lssd_pkg::STAT_OK;
                ctl.out_last    = 1'b1;
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SWAP_A: begin
                alu_b         = lssd_pkg::PTR_M2;
                ctl.tmp_load  = 1'b1;
                ctl.mem_re    = 1'b1;
                ctl.mem_raddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                state_next    = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                ctl.mem_we    = 1'b1;
                ctl.mem_waddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                ctl.wsel      = lssd_pkg::WSEL_RDATA;
                state_next    = ST_SWAP_C;
            end
            ST_SWAP_C: begin
                alu_b         = lssd_pkg::PTR_M2;
                ctl.mem_we    = 1'b1;
                ctl.mem_waddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                ctl.wsel      = lssd_pkg::WSEL_TMP;
                status_next   = lssd_pkg::STAT_OK;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                ctl.out_last = 1'b1;
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUMP: begin
                alu_a           = idx_reg;
                alu_b           = lssd_pkg::PTR_ONE;
                ctl.out_word_rd = 1'b1;
                ctl.out_status  = lssd_pkg::STAT_OK;
                ctl.out_last    = dump_last;
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    idx_next     = alu_sum;
                    if (dump_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ctl.mem_re    = 1'b1;
                        ctl.mem_raddr = alu_sum[lssd_pkg::ADDR_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
            status_reg <= lssd_pkg::STAT_OK;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            status_reg <= status_next;
        end
    end

    `LSSD_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, sp_reg <= lssd_pkg::FULL_LEVEL)
    `LSSD_ASSERT_IMPL(a_load_free, aclk, aresetn, ctl.out_load, out_free)
    `LSSD_ASSERT_IMPL(a_dump_idx, aclk, aresetn, state_reg == ST_DUMP, idx_reg < n_reg && n_reg <= sp_reg)
    `LSSD_ASSERT_NEXT(a_last_idle, aclk, aresetn, ctl.out_load && ctl.out_last, state_reg == ST_IDLE)
    `LSSD_ASSERT_IMPL(a_we_below, aclk, aresetn, ctl.mem_we && !state_reg[0], ctl.mem_waddr < sp_reg[lssd_pkg::ADDR_W-1:0] || sp_reg == lssd_pkg::FULL_LEVEL)

endmodule

`default_nettype wire

/* bench/lssd_checker.sv */
// Result checker for the LIFO stack unit: watches both channels, predicts each
// result from its own stack copy and compares field by field.
// Depends on lssd_pkg.
`default_nettype none

module lssd_checker
    import lssd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        fail_count,
    output int        pending_results,
    output int        results_checked
);

    logic [WORD_W-1:0] word_stack [STACK_DEPTH];
    int                stack_fill = 0;
    out_item_t         expected_results [$];
    int                fails = 0;
    int                checked = 0;

    function automatic void queue_result(logic [WORD_W-1:0] word, status_t st, logic fin);
        out_item_t r;
        r.word_out   = word;
        r.status     = st;
        r.fill_level = CNT_W'(stack_fill);
        r.last       = fin;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_stack_op(in_item_t it);
        logic [WORD_W-1:0] held;
        int                n;
        case (it.func)
            FUNC_PUSH: begin
                if (stack_fill < STACK_DEPTH) begin
                    word_stack[stack_fill] = it.push_value;
                    stack_fill++;
                    queue_result('0, STAT_OK, 1'b1);
                end else begin
                    queue_result('0, STAT_FULL, 1'b1);
                end
            end
            FUNC_POP: begin
                if (stack_fill > 0) begin
                    stack_fill--;
                    queue_result(word_stack[stack_fill], STAT_OK, 1'b1);
                end else begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end
            end
            FUNC_PEEK: begin
                if (stack_fill > 0) begin
                    queue_result(word_stack[stack_fill-1], STAT_OK, 1'b1);
                end else begin
                    queue_result('0, STAT_EMPTY, 1'b1);
                end
            end
            FUNC_SWAP: begin
                if (stack_fill >= 2) begin
                    held = word_stack[stack_fill-1];
                    word_stack[stack_fill-1] = word_stack[stack_fill-2];
                    word_stack[stack_fill-2] = held;
                    queue_result('0, STAT_OK, 1'b1);
                end else begin
                    queue_result('0, STAT_FEW, 1'b1);
                end
            end
            FUNC_CLEAR: begin
                stack_fill = 0;
                queue_result('0, STAT_OK, 1'b1);
            end
            FUNC_DUMP: begin
                n = (int'(it.dump_count) < stack_fill) ? int'(it.dump_count) : stack_fill;
                if (n == 0) begin
                    queue_result('0, STAT_NODUMP, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        queue_result(word_stack[i], STAT_OK, i == n - 1);
                    end
                end
            end
            default: begin
                queue_result('0, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic void compare_field(string field, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t  %s mismatch: expected %h, got %h", $time, field, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            expected_results.delete();
            stack_fill = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t  unexpected result: expected none, got %h", $time, m_item);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    compare_field("word_out", want.word_out, m_item.word_out);
                    compare_field("status", WORD_W'(want.status), WORD_W'(m_item.status));
                    compare_field("fill_level", WORD_W'(want.fill_level),
                                  WORD_W'(m_item.fill_level));
                    compare_field("last", WORD_W'(want.last), WORD_W'(m_item.last));
                end
            end
            if (s_valid && s_ready) begin
                predict_stack_op(s_item);
            end
        end
        fail_count      <= fails;
        pending_results <= expected_results.size();
        results_checked <= checked;
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Top of the LIFO stack unit bench: clock, reset, item stimulus and result
// backpressure in four pacing phases, verdict. Depends on lssd_pkg,
// lssd_checker and lifo_stack_with_swap_and_dump_unit.
`default_nettype none

module tb;
    import lssd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 100;
    localparam int ITEM_W       = $bits(in_item_t);

    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mode_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int fail_count;
    int pending_results;
    int results_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int op_count [8];
    int items_sent     = 0;

    lifo_stack_with_swap_and_dump_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    lssd_checker stack_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t  timeout with %0d results outstanding", $time, pending_results);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic [2:0] func, logic [WORD_W-1:0] value,
                                           logic [CNT_W-1:0] count);
        in_item_t it;
        it.func       = func;
        it.push_value = value;
        it.dump_count = count;
        return it;
    endfunction

    function automatic in_item_t random_item(mode_t mode);
        in_item_t it;
        int       pick;
        int       count_pick;
        int       value_pick;
        pick       = $urandom_range(99);
        count_pick = $urandom_range(9);
        value_pick = $urandom_range(15);
        it.push_value = {$urandom, $urandom};
        if (value_pick == 0) begin
            it.push_value = '1;
        end else if (value_pick == 1) begin
            it.push_value = '0;
        end
        if (count_pick < 5) begin
            it.dump_count = CNT_W'($urandom_range(0, 6));
        end else if (count_pick < 7) begin
            it.dump_count = CNT_W'($urandom_range(0, 127));
        end else if (count_pick == 7) begin
            it.dump_count = FULL_LEVEL;
        end else if (count_pick == 8) begin
            it.dump_count = '1;
        end else begin
            it.dump_count = '0;
        end
        case (mode)
            MODE_FILL: begin
                it.func = (pick < 92) ? FUNC_PUSH : 3'($urandom_range(1, 7));
            end
            MODE_DRAIN: begin
                if (pick < 55) begin
                    it.func = FUNC_POP;
                end else if (pick < 70) begin
                    it.func = FUNC_PEEK;
                end else if (pick < 80) begin
                    it.func = FUNC_SWAP;
                end else if (pick < 90) begin
                    it.func = FUNC_DUMP;
                end else begin
                    it.func = 3'($urandom_range(0, 7));
                end
            end
            default: begin
                it.func = 3'($urandom_range(0, 7));
            end
        endcase
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            s_item  = ITEM_W'({$urandom, $urandom, $urandom});
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item  = it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        op_count[it.func]++;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit start_with_fill);
        mode_t mode;
        int    burst_left;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        mode           = MODE_FILL;
        burst_left     = start_with_fill ? 72 : 0;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (burst_left == 0) begin
                mode       = mode_t'($urandom_range(0, 2));
                burst_left = $urandom_range(20, 80);
            end
            burst_left--;
            send_item(random_item(mode));
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        send_item(make_item(FUNC_POP,    '0, '0));
        send_item(make_item(FUNC_PEEK,   '1, '1));
        send_item(make_item(FUNC_SWAP,   '0, '0));
        send_item(make_item(FUNC_DUMP,   '0, CNT_W'(5)));
        send_item(make_item(FUNC_PUSH,   '1, '0));
        send_item(make_item(FUNC_SWAP,   '0, '0));
        send_item(make_item(FUNC_PUSH,   '0, '1));
        send_item(make_item(FUNC_PUSH,   {16{4'h5}}, '0));
        send_item(make_item(FUNC_PEEK,   '0, '0));
        send_item(make_item(FUNC_SWAP,   '0, '0));
        send_item(make_item(FUNC_PEEK,   '0, '0));
        send_item(make_item(FUNC_DUMP,   '0, '0));
        send_item(make_item(FUNC_DUMP,   '0, '1));
        send_item(make_item(FUNC_DUMP,   '0, CNT_W'(2)));
        send_item(make_item(FUNC_SPARE6, '1, '1));
        send_item(make_item(FUNC_SPARE7, '0, '0));
        send_item(make_item(FUNC_POP,    '0, '0));
        send_item(make_item(FUNC_POP,    '0, '0));
        send_item(make_item(FUNC_POP,    '0, '0));
        send_item(make_item(FUNC_POP,    '0, '0));
        send_item(make_item(FUNC_PUSH,   {16{4'ha}}, '0));
        send_item(make_item(FUNC_CLEAR,  '1, '1));
        send_item(make_item(FUNC_DUMP,   '0, FULL_LEVEL));
        send_item(make_item(FUNC_PUSH,   64'd1, '0));

        run_phase(0, 0, 1'b1);
        run_phase(67, 0, 1'b0);
        run_phase(0, 67, 1'b1);
        run_phase(20, 20, 1'b0);

        s_valid = 1'b0;
        while (pending_results != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Summary: %0d items: push %0d, pop %0d, peek %0d, swap %0d,",
                 items_sent, op_count[FUNC_PUSH], op_count[FUNC_POP], op_count[FUNC_PEEK],
                 op_count[FUNC_SWAP]);
        $display("Summary: clear %0d, dump %0d, spare %0d",
                 op_count[FUNC_CLEAR], op_count[FUNC_DUMP],
                 op_count[FUNC_SPARE6] + op_count[FUNC_SPARE7]);
        $display("Summary: %0d results checked over four pacing phases, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
